FILE: design/child_index_select_top_assert.svh
// Assertion helpers for the child index select block.
`ifndef CHILD_INDEX_SELECT_TOP_ASSERT_SVH
`define CHILD_INDEX_SELECT_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define CIS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define CIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/cis_pkg.sv
`timescale 1ns / 1ps

package cis_pkg;

   // Field widths of the request and response beats
   localparam int OPCODE_W = 2;
   localparam int COUNT_W  = 32;
   localparam int LOC_W    = 40;
   localparam int INDEX_W  = 8;

   // Opcodes; code 3 is unused and ignored
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT
   } state_type;

endpackage

FILE: design/child_index_select_top.sv
`timescale 1ns / 1ps
// Child index select: holds the per-child element counts of one tree node
// (up to MAX_ENTRIES of them) and answers location queries against them.
// A clear beat empties the node, an append beat adds one count at the end
// (dropped when the node is full), and a query beat returns the first child
// whose running count total exceeds the location, with the total of the
// children to its left; past the end it returns the last child. A query on
// an empty node returns empty_error with zero fields. Only queries give a
// response beat. Clear and append are done as their beat is taken. A query
// on a node of two or more entries walks the count memory one entry per
// cycle in ST_SCAN, through the single 41-bit add and compare (the last
// count is never scanned, and the memory read for the next entry overlaps
// the compare of the current one); an empty or one-entry node skips the
// scan. ST_WAIT then loads the response register once it is free.
// req_ready stays low throughout, so a query holds the request side from
// its own beat until its response is loaded. A response may wait in its
// register while clear and append beats carry on; a following query
// finishes its scan and then waits for the register to free up.
// The count memory needs no clearing pass: only written entries are read.

`include "child_index_select_top_assert.svh"

module child_index_select_top
   import cis_pkg::*;
#(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [COUNT_W-1:0]  req_child_count,
   input  logic [LOC_W-1:0]    req_location,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [INDEX_W-1:0]  rsp_child_index,
   output logic [LOC_W-1:0]    rsp_left_total,
   output logic                rsp_empty_error
);

   localparam int IDX_W  = $clog2(MAX_ENTRIES);
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int SUM_W  = LOC_W + 1;
   localparam int WIDE_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

   // count memory
   logic [COUNT_W-1:0] count_store_ff [MAX_ENTRIES];
   logic [COUNT_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   wr_addr;
   logic               mem_we;

   // sequencer and scan state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   entry_total_ff, entry_total_in;
   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [LOC_W-1:0]   left_ff, left_in;
   logic [LOC_W-1:0]   loc_ff, loc_in;
   logic               err_ff, err_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [LOC_W-1:0]   rsp_left_ff, rsp_left_in;
   logic               rsp_err_ff, rsp_err_in;

   logic               req_accept;
   logic               rsp_free;
   logic [CNT_W-1:0]   cnt_minus;
   logic [IDX_W-1:0]   last_idx;
   logic [IDX_W-1:0]   next_idx;
   logic [SUM_W-1:0]   run_sum;
   logic               hit;
   logic [WIDE_W-1:0]  idx_wide;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   assign cnt_minus = entry_total_ff - CNT_W'(1);
   assign last_idx  = cnt_minus[IDX_W-1:0];
   assign next_idx  = scan_idx_ff + IDX_W'(1);

   // the shared adder: running total up to and including the current entry
   assign run_sum = {1'b0, left_ff} + SUM_W'(rd_data_ff);
   assign hit     = ({1'b0, loc_ff} < run_sum);
   assign idx_wide = WIDE_W'(scan_idx_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_opcode == OP_QUERY) begin
               if (entry_total_ff > CNT_W'(1)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_WAIT;
               end
            end
         end
         ST_SCAN: begin
            if (hit || next_idx == last_idx) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      entry_total_in = entry_total_ff;
      scan_idx_in    = scan_idx_ff;
      left_in        = left_ff;
      loc_in         = loc_ff;
      err_in         = err_ff;
      rd_addr        = '0;
      wr_addr        = entry_total_ff[IDX_W-1:0];
      mem_we         = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_idx_in     = rsp_idx_ff;
      rsp_left_in    = rsp_left_ff;
      rsp_err_in     = rsp_err_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // entry 0 is read here so the scan starts with its data in hand
            rd_addr = '0;
            if (req_accept) begin
               unique case (req_opcode)
                  OP_CLEAR: begin
                     entry_total_in = '0;
                  end
                  OP_APPEND: begin
                     if (entry_total_ff < CNT_W'(MAX_ENTRIES)) begin
                        mem_we         = 1'b1;
                        entry_total_in = entry_total_ff + CNT_W'(1);
                     end
                  end
                  OP_QUERY: begin
                     loc_in      = req_location;
                     scan_idx_in = '0;
                     left_in     = '0;
                     err_in      = (entry_total_ff == '0);
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            rd_addr = next_idx;
            if (!hit) begin
               // past this entry: no overflow, run_sum <= location here
               left_in     = run_sum[LOC_W-1:0];
               scan_idx_in = next_idx;
            end
         end
         ST_WAIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = idx_wide[INDEX_W-1:0];
               rsp_left_in  = left_ff;
               rsp_err_in   = err_ff;
            end
         end
         default: ;
      endcase
   end

   // count memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_store_ff[wr_addr] <= req_child_count;
      end
      rd_data_ff <= count_store_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_total_ff <= entry_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      scan_idx_ff <= scan_idx_in;
      left_ff     <= left_in;
      loc_ff      <= loc_in;
      err_ff      <= err_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_left_ff <= rsp_left_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_child_index = rsp_idx_ff;
   assign rsp_left_total  = rsp_left_ff;
   assign rsp_empty_error = rsp_err_ff;

   // checks
   `CIS_ASSERT_NOW(a_total_bound, clock, reset, 1'b1,
      entry_total_ff <= CNT_W'(MAX_ENTRIES), "entry count beyond node size")
   `CIS_ASSERT_NOW(a_scan_below_last, clock, reset, state_ff == ST_SCAN,
      scan_idx_ff < last_idx, "scan ran onto the last entry")
   `CIS_ASSERT_NOW(a_left_not_past_loc, clock, reset, state_ff == ST_SCAN,
      left_ff <= loc_ff, "left total passed the location")
   `CIS_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid_ff && rsp_err_ff,
      rsp_idx_ff == '0 && rsp_left_ff == '0, "empty node response not zero")
   `CIS_ASSERT_NEXT(a_query_starts_scan, clock, reset,
      req_accept && req_opcode == OP_QUERY && entry_total_ff > CNT_W'(1),
      state_ff == ST_SCAN, "query on a multi-entry node skipped the scan")

endmodule

FILE: dv/child_index_select_top_test.sv
`timescale 1ns / 1ps

module child_index_select_top_test;
   import cis_pkg::*;

   localparam int MAX_ENTRIES = 256;
   // opcode 3 has no name in the package; the block must ignore it
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   // longest quiet spell: full scan of 256 counts plus response stalls, several times over
   localparam int STALL_LIMIT = 3000;
   // settle time after the last response: one full scan and some margin
   localparam int TAIL_CYCLES = 300;
   // useful beats (clear, append that lands, query) to send before stopping
   localparam int RANDOM_BEATS = 750;
   // useful beats sent flat out once the run is under way
   localparam int BURST_BEATS = 120;

   typedef struct packed {
      logic [INDEX_W-1:0] child_index;
      logic [LOC_W-1:0]   left_total;
      logic               empty_error;
   } pick_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OPCODE_W-1:0] req_opcode = OP_CLEAR;
   logic [COUNT_W-1:0]  req_child_count = '0;
   logic [LOC_W-1:0]    req_location = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [INDEX_W-1:0]  rsp_child_index;
   logic [LOC_W-1:0]    rsp_left_total;
   logic                rsp_empty_error;

   // Shadow of the node: counts in append order and the number held
   logic [COUNT_W-1:0] child_counts [MAX_ENTRIES];
   int                 node_entries = 0;

   // Picks still owed by the block, oldest first
   pick_type pending_picks [$];

   int req_idle_pct = 37;
   int rsp_idle_pct = 37;
   int fail_count = 0;
   int useful_beats = 0;
   int queries_sent = 0;
   int empty_queries = 0;
   int dropped_appends = 0;
   int deepest_node = 0;
   int quiet_cycles = 0;
   int burst_start = -1;

   child_index_select_top #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_child_count(req_child_count),
      .req_location   (req_location),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_child_index(rsp_child_index),
      .rsp_left_total (rsp_left_total),
      .rsp_empty_error(rsp_empty_error)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Walk the counts with a running total; the first child whose running total
   // passes the location wins, the last child catches everything beyond.
   function automatic pick_type locate_child(input logic [LOC_W-1:0] loc);
      pick_type       pick;
      logic [LOC_W:0] running;
      logic [LOC_W:0] left;
      int             idx;
      bit             hit;
      pick = '0;
      running = '0;
      left = '0;
      idx = 0;
      hit = 1'b0;
      if (node_entries == 0) begin
         pick.empty_error = 1'b1;
         return pick;
      end
      while (idx + 1 < node_entries && !hit) begin
         running += (LOC_W + 1)'(child_counts[idx]);
         if ({1'b0, loc} < running) begin
            hit = 1'b1;
         end else begin
            left += (LOC_W + 1)'(child_counts[idx]);
            idx++;
         end
      end
      pick.child_index = idx[INDEX_W-1:0];
      pick.left_total = left[LOC_W-1:0];
      return pick;
   endfunction

   // Full-range location for payloads that the block ignores
   function automatic logic [LOC_W-1:0] noise_location();
      return LOC_W'({$urandom, $urandom});
   endfunction

   // Update the shadow node for one accepted beat
   task automatic apply_beat(input logic [OPCODE_W-1:0] op, input logic [COUNT_W-1:0] cnt,
                             input logic [LOC_W-1:0] loc);
      case (op)
         OP_CLEAR: begin
            node_entries = 0;
            useful_beats++;
         end
         OP_APPEND: begin
            if (node_entries < MAX_ENTRIES) begin
               child_counts[node_entries] = cnt;
               node_entries++;
               useful_beats++;
               if (node_entries > deepest_node) deepest_node = node_entries;
            end else begin
               dropped_appends++;
            end
         end
         OP_QUERY: begin
            pending_picks.push_back(locate_child(loc));
            queries_sent++;
            useful_beats++;
            if (node_entries == 0) empty_queries++;
         end
         default: ;
      endcase
   endtask

   // Present one beat and hold it until taken. Called on a rising edge; returns on one.
   // Valid stays high into the next beat unless an idle gap is drawn.
   task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic [COUNT_W-1:0] cnt,
                            input logic [LOC_W-1:0] loc);
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_child_count <= cnt;
      req_location    <= loc;
      do @(posedge clock); while (!req_ready);
      apply_beat(op, cnt, loc);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid       <= 1'b0;
         req_opcode      <= OP_UNUSED;
         req_child_count <= $urandom;
         req_location    <= noise_location();
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic append_count(input logic [COUNT_W-1:0] cnt);
      send_beat(OP_APPEND, cnt, noise_location());
   endtask

   task automatic query_at(input logic [LOC_W-1:0] loc);
      send_beat(OP_QUERY, $urandom, loc);
   endtask

   // Hold the sender off until every owed pick is back
   task automatic drain_picks();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_picks.size() != 0) @(posedge clock);
   endtask

   // Counts: plenty of zeros, small values and the top value around full-range noise
   function automatic logic [COUNT_W-1:0] random_count();
      int mode;
      mode = $urandom_range(99);
      if (mode < 30) return $urandom_range(0, 20);
      if (mode < 45) return '0;
      if (mode < 55) return {COUNT_W{1'b1}};
      return $urandom;
   endfunction

   // Locations mostly inside the node, a good share right on a child boundary
   function automatic logic [LOC_W-1:0] pick_location();
      logic [63:0] node_sum;
      logic [63:0] bound_sum;
      logic [63:0] raw;
      int          mode;
      int          j;
      int          k;
      node_sum = '0;
      bound_sum = '0;
      raw = {$urandom, $urandom};
      mode = $urandom_range(99);
      for (j = 0; j < node_entries; j++) node_sum += 64'(child_counts[j]);
      if (mode < 40) begin
         raw = raw % (node_sum + 64'd1);
         return raw[LOC_W-1:0];
      end
      if (mode < 70 && node_entries > 0) begin
         j = $urandom_range(node_entries - 1);
         for (k = 0; k <= j; k++) bound_sum += 64'(child_counts[k]);
         if ($urandom_range(1) == 1 && bound_sum != 0) bound_sum--;
         return bound_sum[LOC_W-1:0];
      end
      if (mode < 90) return raw[LOC_W-1:0];
      if ($urandom_range(1) == 1) return {LOC_W{1'b1}};
      return '0;
   endfunction

   // Queries on an empty node, and the unused opcode leaving it empty
   task automatic test_empty_node();
      query_at('0);
      query_at({LOC_W{1'b1}});
      send_beat(OP_UNUSED, {COUNT_W{1'b1}}, {LOC_W{1'b1}});
      query_at(40'd5);
      send_beat(OP_CLEAR, $urandom, noise_location());
      query_at(40'd1);
   endtask

   // Zero and top counts, locations on and either side of the boundaries
   task automatic test_field_extremes();
      append_count('0);
      append_count({COUNT_W{1'b1}});
      append_count(32'd5);
      append_count(32'd1);
      query_at('0);
      query_at(40'hFF_FFFF_FFFE);
      query_at(40'hFF_FFFF_FFFF);
      query_at(40'h1_0000_0003);
      query_at(40'h1_0000_0004);
      query_at({LOC_W{1'b1}});
      // unused opcode with a live payload must not disturb the node
      send_beat(OP_UNUSED, 32'hDEAD_BEEF, 40'd7);
      query_at(40'h1_0000_0004);
   endtask

   // One child: the scan never runs, index 0 and nothing to its left
   task automatic test_single_entry();
      send_beat(OP_CLEAR, $urandom, noise_location());
      append_count(32'd9);
      query_at(40'd3);
      query_at({LOC_W{1'b1}});
   endtask

   // Fill to capacity, mostly with top counts so left_total reaches its upper bits,
   // then appends past the end that must be dropped
   task automatic test_capacity();
      int n;
      drain_picks();
      send_beat(OP_CLEAR, $urandom, noise_location());
      for (n = 0; n < MAX_ENTRIES; n++) begin
         append_count(($urandom_range(7) != 0) ? {COUNT_W{1'b1}} : random_count());
      end
      repeat (3) append_count(random_count());
      query_at({LOC_W{1'b1}});
      query_at('0);
      repeat (4) query_at(pick_location());
      append_count(random_count());
      query_at(pick_location());
   endtask

   // Clear, build a node, query it; now and then noise, broken sequences or a pause
   task automatic test_random_sequences();
      int kind;
      int n;
      int q;
      while (useful_beats < RANDOM_BEATS) begin
         // one long stretch with both sides flat out
         if (burst_start < 0 && useful_beats >= 300) burst_start = useful_beats;
         if (burst_start >= 0 && useful_beats < burst_start + BURST_BEATS) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 37;
            rsp_idle_pct = 37;
         end
         kind = $urandom_range(99);
         if (kind < 4) begin
            send_beat(OP_UNUSED, $urandom, noise_location());
         end else if (kind < 8) begin
            send_beat(OP_CLEAR, $urandom, noise_location());
            query_at(pick_location());
         end else if (kind < 11) begin
            drain_picks();
         end else if (kind < 16) begin
            // broken sequence: no clear, queries and appends on whatever is there
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(1) == 1) append_count(random_count());
               else query_at(pick_location());
            end
         end else begin
            send_beat(OP_CLEAR, $urandom, noise_location());
            if (kind < 18) n = $urandom_range(200, MAX_ENTRIES + 4);
            else if (kind < 30) n = $urandom_range(13, 64);
            else n = $urandom_range(1, 12);
            repeat (n) append_count(random_count());
            q = $urandom_range(1, 6);
            repeat (q) begin
               if ($urandom_range(9) == 0) append_count(random_count());
               query_at(pick_location());
            end
         end
      end
      req_idle_pct = 37;
      rsp_idle_pct = 37;
   endtask

   // Response side: random back-pressure, off during reset
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= rsp_idle_pct);
   end

   // Compare each response beat with the oldest owed pick
   always @(posedge clock) begin
      pick_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_picks.size() == 0) begin
            $error("response beat with no query owed: child_index %0d left_total %0h",
                   rsp_child_index, rsp_left_total);
            fail_count++;
         end else begin
            want = pending_picks.pop_front();
            if (rsp_child_index !== want.child_index) begin
               $error("child_index: expected %0d, got %0d", want.child_index, rsp_child_index);
               fail_count++;
            end
            if (rsp_left_total !== want.left_total) begin
               $error("left_total: expected %0h, got %0h", want.left_total, rsp_left_total);
               fail_count++;
            end
            if (rsp_empty_error !== want.empty_error) begin
               $error("empty_error: expected %0b, got %0b", want.empty_error, rsp_empty_error);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: too long without a beat moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL child_index_select_top");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_node();
      test_field_extremes();
      test_single_entry();
      test_capacity();
      test_random_sequences();
      drain_picks();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_picks.size() != 0) begin
         $error("%0d picks never returned", pending_picks.size());
         fail_count++;
      end
      $display("Run covered %0d queries (%0d on an empty node), %0d useful beats,",
               queries_sent, empty_queries, useful_beats);
      $display("nodes up to %0d children and %0d appends dropped on a full node.",
               deepest_node, dropped_appends);
      if (fail_count == 0) begin
         $display("PASS child_index_select_top");
      end else begin
         $display("FAIL child_index_select_top");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/cis_pkg.sv
design/child_index_select_top.sv
dv/child_index_select_top_test.sv
